[src/lru_page_replacement_macros.svh]
// Assertion helpers for the RTL of the page replacement block.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define LRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRU_ASSERT(lbl, prop, msg)
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/lru_pkg.sv]
package lru_pkg;

    // Width and reset value of the frames_in_use register
    localparam int unsigned CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

    // Width of the saturating fault counter
    localparam int unsigned FAULT_W = 32;
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // Broadcast from the top level to every frame cell
    typedef struct packed {
        logic advance;  // an input transfer happens this cycle
        logic found;    // the page matched a resident frame
        logic evict;    // miss with full frames: drop the least recent page
    } step_ctrl_t;

endpackage

[src/lru_cell.sv]
module lru_cell #(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = 16,
    parameter int CNT_W     = 4
) (
    input  logic                   aclk,
    input  logic [PAGE_BITS-1:0]   new_page,
    input  logic [PAGE_BITS-1:0]   next_page,
    input  logic [CNT_W-1:0]       count,
    input  logic                   seen_in,
    input  lru_pkg::step_ctrl_t    ctrl,
    output logic                   match,
    output logic                   seen_out,
    output logic [PAGE_BITS-1:0]   page_q
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 occupied;
    logic                 is_last;
    logic                 is_free;

    // Position of this cell relative to the fill level
    assign occupied = IDX_C < count;
    assign is_last  = count == IDX_P1;
    assign is_free  = count == IDX_C;

    // Compare and pass the hit mark toward the most recent end
    assign match    = occupied && (page_reg == new_page);
    assign seen_out = seen_in || match;

    // Shift down from the hit or eviction point, or load the appended page
    always_comb begin
        page_next = page_reg;
        if (ctrl.advance) begin
            if (ctrl.found || ctrl.evict) begin
                if ((seen_out || ctrl.evict) && occupied) begin
                    page_next = is_last ? new_page : next_page;
                end
            end else if (is_free) begin
                page_next = new_page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

    assign page_q = page_reg;

endmodule

[src/lru_page_replacement.sv]
// LRU page replacement over a chain of frame cells.
// The result of an input transfer is registered and shows on m_tvalid in the next cycle.
// Throughput: one reference per cycle; the compare, hit chain and shift of all
// frame cells settle combinationally. A new reference enters in the cycle the
// waiting result is taken and is held off while that result stays untaken.
// Reset clears fill level, fault count and output valid; frames_in_use returns to 4.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: frames_in_use
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]     cfg_data,
    // s_tdata fields from bit 0: page
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0] s_tdata,
    // m_tdata fields from bit 0: hit, fault, evicted_valid, evicted_page,
    // occupied, fault_total
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((3+PAGE_BITS+$clog2(MAX_FRAMES+1)+lru_pkg::FAULT_W+7)/8)*8-1:0] m_tdata
);

    localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int CAP_W    = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;
    localparam int OUT_BITS = 3 + PAGE_BITS + CNT_W + lru_pkg::FAULT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_FRAMES);
    localparam logic [CAP_W-1:0] CAP_ONE = CAP_W'(1);

    logic [lru_pkg::CFG_W-1:0]   cfg_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [lru_pkg::FAULT_W-1:0] fault_reg;
    logic [lru_pkg::FAULT_W-1:0] fault_next;

    logic                        out_valid_reg;
    logic                        hit_reg;
    logic                        evict_reg;
    logic [PAGE_BITS-1:0]        victim_reg;

    logic                        in_fire;
    logic [PAGE_BITS-1:0]        page;
    logic [CAP_W-1:0]            cfg_ext;
    logic [CAP_W-1:0]            cap;
    logic                        found;
    logic                        evict;
    lru_pkg::step_ctrl_t         ctrl;

    logic [MAX_FRAMES:0]         seen;
    logic [MAX_FRAMES-1:0]       match;
    logic [PAGE_BITS-1:0]        cell_page [MAX_FRAMES];

    // Configuration is always accepted; input while the output register is empty or being drained
    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign page      = s_tdata[PAGE_BITS-1:0];

    // Clamp the configured frame count to one through MAX_FRAMES
    assign cfg_ext = CAP_W'(cfg_reg);
    always_comb begin
        priority if (cfg_reg == '0) begin
            cap = CAP_ONE;
        end else if (cfg_ext > CAP_MAX) begin
            cap = CAP_MAX;
        end else begin
            cap = cfg_ext;
        end
    end

    assign found = seen[MAX_FRAMES];
    assign evict = !found && (CAP_W'(count_reg) >= cap);

    assign ctrl.advance = in_fire;
    assign ctrl.found   = found;
    assign ctrl.evict   = evict;

    // Frame cells, least recent at index zero
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        logic [PAGE_BITS-1:0] next_page;
        if (i == MAX_FRAMES - 1) begin : g_tail
            assign next_page = page;
        end else begin : g_mid
            assign next_page = cell_page[i+1];
        end
        lru_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .new_page  (page),
            .next_page (next_page),
            .count     (count_reg),
            .seen_in   (seen[i]),
            .ctrl      (ctrl),
            .match     (match[i]),
            .seen_out  (seen[i+1]),
            .page_q    (cell_page[i])
        );
    end

    // Grow on an append, count faults with saturation
    always_comb begin
        count_next = count_reg;
        fault_next = fault_reg;
        if (in_fire && !found) begin
            if (!evict) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (fault_reg != lru_pkg::FAULT_MAX) begin
                fault_next = fault_reg + lru_pkg::FAULT_W'(1);
            end
        end
    end

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= lru_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_data;
        end
    end

    // Advance the recency state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            fault_reg <= '0;
        end else begin
            count_reg <= count_next;
            fault_reg <= fault_next;
        end
    end

    // Output valid: set on an input transfer, drop once the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            hit_reg    <= found;
            evict_reg  <= evict;
            victim_reg <= evict ? cell_page[0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({fault_reg, count_reg, victim_reg, evict_reg, !hit_reg, hit_reg});

    `LRU_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_FRAMES), "fill level above frame count")
    `LRU_ASSERT(a_single_match, $onehot0(match), "page resident in more than one frame")
    `LRU_ASSERT(a_evict_is_fault, !(m_tvalid && evict_reg && hit_reg), "eviction on a hit")
    `LRU_ASSERT_NEXT(a_fault_step, in_fire && !found && (fault_reg != lru_pkg::FAULT_MAX),
        fault_reg == $past(fault_reg) + lru_pkg::FAULT_W'(1), "fault count did not advance")
    `LRU_ASSERT_NEXT(a_count_hold, in_fire && (found || evict),
        count_reg == $past(count_reg), "fill level changed on hit or eviction")

endmodule
